// ===== rtl/core/bktp_pkg.sv =====
// ----------------------------------------------------------------------------
// bktp_pkg
// Shared types and constants for the block key text parser.
// ----------------------------------------------------------------------------
`default_nettype none

package bktp_pkg;

    // Verdict codes, in priority order after OK
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_HASH_LEN = 3'd1;
    localparam logic [2:0] STATUS_COLONS   = 3'd2;
    localparam logic [2:0] STATUS_NUMBER   = 3'd3;
    localparam logic [2:0] STATUS_CANON    = 3'd4;

    // Field being parsed
    localparam logic [1:0] FIELD_HASH   = 2'd0;
    localparam logic [1:0] FIELD_LENGTH = 2'd1;
    localparam logic [1:0] FIELD_MODEL  = 2'd2;
    localparam logic [1:0] FIELD_EXTRA  = 2'd3;

    localparam logic [4:0] HASH_DIGITS   = 5'd16;
    localparam logic [4:0] HASH_CNT_SAT  = 5'd17;
    localparam logic [1:0] DEC_CNT_SAT   = 2'd2;

    localparam logic [7:0] CHAR_COLON = 8'h3a;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_LC_A  = 8'h61;
    localparam logic [7:0] CHAR_LC_F  = 8'h66;
    localparam logic [7:0] CHAR_UC_A  = 8'h41;
    localparam logic [7:0] CHAR_UC_F  = 8'h46;

    typedef struct packed {
        logic       is_colon;
        logic       is_dec;
        logic       is_hex_lower;
        logic       is_hex_upper;
        logic [3:0] digit;
    } t_char_class;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] hash_value;
        logic [31:0] length_value;
        logic [31:0] fingerprint_value;
    } t_verdict;

endpackage

`default_nettype wire

// ===== rtl/core/bktp_char_decode.sv =====
// ----------------------------------------------------------------------------
// bktp_char_decode
// Classifies one key string byte and gives its hex/decimal digit value.
// ----------------------------------------------------------------------------
`default_nettype none

module bktp_char_decode (
    input  wire logic [7:0]           i_character,
    output bktp_pkg::t_char_class     o_class
);
    import bktp_pkg::*;

    always_comb begin
        o_class.is_colon     = (i_character == CHAR_COLON);
        o_class.is_dec       = (i_character >= CHAR_ZERO) && (i_character <= CHAR_NINE);
        o_class.is_hex_lower = (i_character >= CHAR_LC_A) && (i_character <= CHAR_LC_F);
        o_class.is_hex_upper = (i_character >= CHAR_UC_A) && (i_character <= CHAR_UC_F);
        // 'a'/'A' have low nibble 1, so letters map to nibble + 9
        if (o_class.is_dec) begin
            o_class.digit = i_character[3:0];
        end else if (o_class.is_hex_lower || o_class.is_hex_upper) begin
            o_class.digit = i_character[3:0] + 4'd9;
        end else begin
            o_class.digit = 4'd0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/bktp_parse_state.sv =====
// ----------------------------------------------------------------------------
// bktp_parse_state
// Per-string parse state, its one-byte update, and the verdict for the
// final byte. State clears after the final byte of each string.
// ----------------------------------------------------------------------------
`default_nettype none

module bktp_parse_state (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_step,
    input  wire logic                  i_last,
    input  wire bktp_pkg::t_char_class i_class,
    output bktp_pkg::t_verdict         o_verdict
);
    import bktp_pkg::*;

    logic [1:0]  r_field,   n_field;
    logic [4:0]  r_hcnt,    n_hcnt;
    logic [63:0] r_hash,    n_hash;
    logic [31:0] r_len,     n_len;
    logic [31:0] r_fp,      n_fp;
    logic [1:0]  r_dcnt,    n_dcnt;
    logic        r_lz,      n_lz;
    logic        r_err_hl,  n_err_hl;
    logic        r_err_num, n_err_num;
    logic        r_err_can, n_err_can;

    logic [31:0] dec_acc;
    logic [35:0] dec_next;
    logic        fin_num;
    logic        fin_can;

    assign dec_acc  = (r_field == FIELD_LENGTH) ? r_len : r_fp;
    // acc * 10 + digit
    assign dec_next = {1'b0, dec_acc, 3'b000} + {3'b000, dec_acc, 1'b0}
                    + {32'd0, i_class.digit};

    always_comb begin
        n_field   = r_field;
        n_hcnt    = r_hcnt;
        n_hash    = r_hash;
        n_len     = r_len;
        n_fp      = r_fp;
        n_dcnt    = r_dcnt;
        n_lz      = r_lz;
        n_err_hl  = r_err_hl;
        n_err_num = r_err_num;
        n_err_can = r_err_can;

        if (i_class.is_colon) begin
            case (r_field)
                FIELD_HASH: begin
                    if (r_hcnt != HASH_DIGITS) begin
                        n_err_hl = 1'b1;
                    end
                    n_field = FIELD_LENGTH;
                end
                FIELD_LENGTH: begin
                    if (r_dcnt == 2'd0) begin
                        n_err_num = 1'b1;
                    end else if (r_dcnt == DEC_CNT_SAT && r_lz) begin
                        n_err_can = 1'b1;
                    end
                    n_dcnt  = 2'd0;
                    n_lz    = 1'b0;
                    n_field = FIELD_MODEL;
                end
                default: begin
                    n_field = FIELD_EXTRA;
                end
            endcase
        end else begin
            case (r_field)
                FIELD_HASH: begin
                    if (r_hcnt < HASH_CNT_SAT) begin
                        n_hcnt = r_hcnt + 5'd1;
                    end
                    if (n_hcnt <= HASH_DIGITS) begin
                        if (i_class.is_hex_upper) begin
                            n_err_can = 1'b1;
                        end else if (!i_class.is_dec && !i_class.is_hex_lower) begin
                            n_err_num = 1'b1;
                        end
                        n_hash = {r_hash[59:0], i_class.digit};
                    end
                end
                FIELD_LENGTH, FIELD_MODEL: begin
                    if (!i_class.is_dec) begin
                        n_err_num = 1'b1;
                    end else begin
                        if (r_dcnt == 2'd0 && i_class.digit == 4'd0) begin
                            n_lz = 1'b1;
                        end
                        if (r_dcnt < DEC_CNT_SAT) begin
                            n_dcnt = r_dcnt + 2'd1;
                        end
                        if (dec_next[35:32] != 4'd0) begin
                            n_err_num = 1'b1;
                        end else if (r_field == FIELD_LENGTH) begin
                            n_len = dec_next[31:0];
                        end else begin
                            n_fp = dec_next[31:0];
                        end
                    end
                end
                default: begin
                    // bytes past a third colon are ignored
                end
            endcase
        end
    end

    // Verdict on the updated state; the model field is closed here
    assign fin_num = n_err_num || (n_dcnt == 2'd0);
    assign fin_can = n_err_can || (n_dcnt == DEC_CNT_SAT && n_lz);

    always_comb begin
        if (n_field == FIELD_HASH || n_err_hl) begin
            o_verdict.status = STATUS_HASH_LEN;
        end else if (n_field != FIELD_MODEL) begin
            o_verdict.status = STATUS_COLONS;
        end else if (fin_num) begin
            o_verdict.status = STATUS_NUMBER;
        end else if (fin_can) begin
            o_verdict.status = STATUS_CANON;
        end else begin
            o_verdict.status = STATUS_OK;
        end
        if (o_verdict.status == STATUS_OK) begin
            o_verdict.hash_value        = n_hash;
            o_verdict.length_value      = n_len;
            o_verdict.fingerprint_value = n_fp;
        end else begin
            o_verdict.hash_value        = 64'd0;
            o_verdict.length_value      = 32'd0;
            o_verdict.fingerprint_value = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && i_last)) begin
            r_field   <= FIELD_HASH;
            r_hcnt    <= 5'd0;
            r_hash    <= 64'd0;
            r_len     <= 32'd0;
            r_fp      <= 32'd0;
            r_dcnt    <= 2'd0;
            r_lz      <= 1'b0;
            r_err_hl  <= 1'b0;
            r_err_num <= 1'b0;
            r_err_can <= 1'b0;
        end else if (i_step) begin
            r_field   <= n_field;
            r_hcnt    <= n_hcnt;
            r_hash    <= n_hash;
            r_len     <= n_len;
            r_fp      <= n_fp;
            r_dcnt    <= n_dcnt;
            r_lz      <= n_lz;
            r_err_hl  <= n_err_hl;
            r_err_num <= n_err_num;
            r_err_can <= n_err_can;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/block_key_text_parser_core.sv =====
// ----------------------------------------------------------------------------
// block_key_text_parser_core
// Parses a hash:length:model key string one byte per transaction and returns
// one verdict transaction for the byte marked last.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  input   | in  | i_valid / o_ready  | i_character, i_is_last
//  result  | out | o_valid / i_ready  | o_status, o_hash_value,
//          |     |                    | o_length_value, o_fingerprint_value
//
// One byte per cycle unless a last byte is stalled: a byte sits in the input
// register while the parse state updates, then the next one follows.
// The verdict is registered in the result register as the last byte leaves
// the input register. A last byte waits in the input register only while an
// unread verdict blocks the result register; other bytes never wait.
// Reset is synchronous, active low, and clears the valid flags and the parse
// state; the input byte and the result payload registers are not reset.
// ----------------------------------------------------------------------------
`default_nettype none

module block_key_text_parser_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_character,
    input  wire logic        i_is_last,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_status,
    output logic [63:0]      o_hash_value,
    output logic [31:0]      o_length_value,
    output logic [31:0]      o_fingerprint_value
);
    import bktp_pkg::*;

    logic        r_in_valid;
    logic [7:0]  r_char;
    logic        r_last;
    logic        r_out_valid;
    t_verdict    r_verdict;

    t_char_class char_class;
    t_verdict    verdict;
    logic        out_free;
    logic        advance;

    assign out_free = !r_out_valid || i_ready;
    assign advance  = r_in_valid && (!r_last || out_free);
    assign o_ready  = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_char <= i_character;
            r_last <= i_is_last;
        end
    end

    bktp_char_decode u_decode (
        .i_character (r_char),
        .o_class     (char_class)
    );

    bktp_parse_state u_state (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_last    (r_last),
        .i_class   (char_class),
        .o_verdict (verdict)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_last) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_last) begin
            r_verdict <= verdict;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_status            = r_verdict.status;
    assign o_hash_value        = r_verdict.hash_value;
    assign o_length_value      = r_verdict.length_value;
    assign o_fingerprint_value = r_verdict.fingerprint_value;

endmodule

`default_nettype wire
